@@ design/dhcp_lease_pool_allocator_top_defines.svh @@
`ifndef DHCP_LEASE_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define DHCP_LEASE_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication on i_clk, off while reset is held
`define DLPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, off while reset is held
`define DLPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dlpa_pkg.sv @@
package dlpa_pkg;

    localparam int IN_TDATA_W  = 184;
    localparam int OUT_TDATA_W = 40;
    localparam int PADDR_W     = 5;

    localparam logic [8:0]  POOL_SIZE_RST = 9'd20;
    localparam logic [31:0] LEASE_RST     = 32'd3600;
    localparam logic [15:0] HOLD_RST      = 16'd30;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SWEEP,
        S_WRITE
    } t_state;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_OFFERED = 2'd1,
        ST_BOUND   = 2'd2
    } t_slot_st;

    typedef enum logic [1:0] {
        ACT_DISCOVER = 2'd0,
        ACT_REQUEST  = 2'd1,
        ACT_RELEASE  = 2'd2,
        ACT_SWEEP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        RK_NONE  = 2'd0,
        RK_OFFER = 2'd1,
        RK_ACK   = 2'd2,
        RK_NAK   = 2'd3
    } t_reply;

    typedef enum logic [2:0] {
        REG_POOL_BASE = 3'd0,
        REG_POOL_SIZE = 3'd1,
        REG_LEASE     = 3'd2,
        REG_HOLD      = 3'd3,
        REG_SERVER    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_slot_st    status;
        logic [47:0] owner;
        logic [31:0] expiry;
    } t_slot;

endpackage

@@ design/dhcp_lease_pool_allocator_top.sv @@
// DHCP lease pool allocator.
// Request words enter on the s_axis channel: tuser carries the action, tdata the
// client MAC, current time, requested-address option, ciaddr and server id.
// One reply word per request leaves on m_axis: tuser carries the reply kind,
// tdata the given address and the slot index. The APB port sets the pool base,
// pool size, lease and offer-hold times and the server address; the user is to
// write them only while idle, which the block itself does not enforce. Each
// request walks the n slots in use (n = pool size, clamped to POOL_SLOTS) through
// a simple dual-port slot memory: one slot read and one write-back a cycle,
// expiring stale slots and noting the lowest owned slot, the lowest free slot
// and the state of the requested slot on the way; a final cycle commits the
// action. The block takes no new word until the reply of the last one is loaded
// into the output register.
// Reset returns the configuration to its defaults and then runs a clearing pass
// over all POOL_SLOTS slots, with s_axis tready low; APB writes are taken.
// A stalled receiver holds the reply word steady; the next request may be taken
// meanwhile, but its reply waits in the final cycle until the register frees.
module dhcp_lease_pool_allocator_top import dlpa_pkg::*; #(
    parameter int POOL_SLOTS = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [47:0] client_mac, [79:48] now_seconds, [80] has_requested_option,
    // [112:81] requested_option_ip, [144:113] client_ip, [145] has_server_id,
    // [177:146] server_id_value, [183:178] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] action
    input  logic [1:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [31:0] your_address, [39:32] slot_index
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [1:0] reply_kind
    output logic [1:0]             o_m_axis_tuser,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = ($clog2(POOL_SLOTS + 1) > 9) ? $clog2(POOL_SLOTS + 1) : 9;

    // configuration
    logic [31:0] r_base;
    logic [8:0]  r_size;
    logic [31:0] r_lease;
    logic [15:0] r_hold;
    logic [31:0] r_server;

    // sequencer
    t_state      r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic        r_p_v;
    logic [IW-1:0] r_p_idx;

    // latched request
    t_action     r_action;
    logic [47:0] r_mac;
    logic [31:0] r_now;
    logic [31:0] r_want;
    logic        r_has_sid;
    logic [31:0] r_sid;

    // derived in the prepare cycle
    logic [CW-1:0] r_n;
    logic [31:0] r_exp;
    logic [IW-1:0] r_off;
    logic        r_in_pool;
    logic        r_sid_bad;

    // search results
    logic        r_own_found;
    logic [IW-1:0] r_own_idx;
    logic        r_free_found;
    logic [IW-1:0] r_free_idx;
    logic        r_req_ok;

    // output register
    logic        r_out_valid;
    t_reply      r_out_kind;
    logic [31:0] r_out_addr;
    logic [7:0]  r_out_slot;

    // slot memory
    t_slot       r_mem [POOL_SLOTS];
    t_slot       r_rd_data;

    logic        s_accept;
    logic        cfg_wr;
    t_reg_idx    reg_idx;

    logic [CW-1:0] pool_n;
    logic [31:0] off_full;
    logic [32:0] exp_sum;
    logic [31:0] exp_addend;

    logic        rd_en;
    logic [IW-1:0] rd_addr;
    logic        wr_en;
    logic [IW-1:0] wr_addr;
    t_slot       wr_data;

    logic        expired, post_free, owned;
    logic        out_free, load_out;
    t_reply      fin_kind;
    logic [31:0] fin_addr;
    logic [7:0]  fin_slot;
    logic        sel_found;
    logic [IW-1:0] sel_idx;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {r_out_slot, r_out_addr};

    // APB: zero wait states, decode on word address
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_comb begin
        unique case (reg_idx)
            REG_POOL_BASE: prdata = r_base;
            REG_POOL_SIZE: prdata = {23'd0, r_size};
            REG_LEASE:     prdata = r_lease;
            REG_HOLD:      prdata = {16'd0, r_hold};
            REG_SERVER:    prdata = r_server;
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= 32'd0;
            r_size   <= POOL_SIZE_RST;
            r_lease  <= LEASE_RST;
            r_hold   <= HOLD_RST;
            r_server <= 32'd0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_POOL_BASE: r_base   <= pwdata;
                REG_POOL_SIZE: r_size   <= pwdata[8:0];
                REG_LEASE:     r_lease  <= pwdata;
                REG_HOLD:      r_hold   <= pwdata[15:0];
                REG_SERVER:    r_server <= pwdata;
                default: ;
            endcase
        end
    end

    // Prepare-cycle arithmetic: clamp the pool, locate the requested slot,
    // and form the saturated expiry for whichever action runs.
    always_comb begin
        pool_n     = ({23'd0, r_size} > 32'(POOL_SLOTS)) ? CW'(POOL_SLOTS) : CW'(r_size);
        off_full   = r_want - r_base;
        exp_addend = (r_action == ACT_DISCOVER) ? {16'd0, r_hold} : r_lease;
        exp_sum    = {1'b0, r_now} + {1'b0, exp_addend};
    end

    // Per-slot view after expiry
    always_comb begin
        expired   = (r_rd_data.status != ST_FREE) && (r_rd_data.expiry <= r_now);
        post_free = (r_rd_data.status == ST_FREE) || expired;
        owned     = !post_free && (r_rd_data.owner == r_mac);
    end

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign load_out = (r_state == S_WRITE) && out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == CW'(POOL_SLOTS - 1)) n_state = S_IDLE;
            S_IDLE:  if (s_accept) n_state = S_PREP;
            S_PREP:  n_state = S_SWEEP;
            S_SWEEP: if (!rd_en && !r_p_v) n_state = S_WRITE;
            S_WRITE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control and commit decision
    always_comb begin
        rd_en     = (r_state == S_SWEEP) && (r_cnt < r_n);
        rd_addr   = r_cnt[IW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_p_idx;
        wr_data   = '{status: ST_FREE, owner: 48'd0, expiry: 32'd0};
        fin_kind  = RK_NONE;
        fin_addr  = 32'd0;
        fin_slot  = 8'd0;
        sel_found = r_own_found || r_free_found;
        sel_idx   = r_own_found ? r_own_idx : r_free_idx;

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[IW-1:0];
            end
            S_SWEEP: begin
                // drop the lease of a slot whose time has run out
                if (r_p_v && expired) begin
                    wr_en   = 1'b1;
                    wr_addr = r_p_idx;
                    wr_data = '{status: ST_FREE, owner: 48'd0, expiry: r_rd_data.expiry};
                end
            end
            S_WRITE: begin
                unique case (r_action)
                    ACT_DISCOVER: begin
                        if (sel_found) begin
                            wr_en    = load_out;
                            wr_addr  = sel_idx;
                            wr_data  = '{status: ST_OFFERED, owner: r_mac, expiry: r_exp};
                            fin_kind = RK_OFFER;
                            fin_addr = r_base + 32'(sel_idx);
                            fin_slot = 8'(sel_idx);
                        end
                    end
                    ACT_REQUEST: begin
                        if (!r_sid_bad) begin
                            if (r_req_ok) begin
                                wr_en    = load_out;
                                wr_addr  = r_off;
                                wr_data  = '{status: ST_BOUND, owner: r_mac, expiry: r_exp};
                                fin_kind = RK_ACK;
                                fin_addr = r_want;
                                fin_slot = 8'(r_off);
                            end else begin
                                fin_kind = RK_NAK;
                            end
                        end
                    end
                    ACT_RELEASE: begin
                        if (r_own_found) begin
                            wr_en    = load_out;
                            wr_addr  = r_own_idx;
                            fin_slot = 8'(r_own_idx);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // slot memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_p_v        <= 1'b0;
            r_own_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_req_ok     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_v   <= rd_en;

            if (r_state == S_CLEAR || rd_en) r_cnt <= r_cnt + CW'(1);
            if (s_accept) r_cnt <= '0;

            if (r_state == S_PREP) begin
                r_own_found  <= 1'b0;
                r_free_found <= 1'b0;
                r_req_ok     <= 1'b0;
            end else if (r_p_v) begin
                // keep only the lowest hit
                if (owned && !r_own_found) r_own_found <= 1'b1;
                if (post_free && !r_free_found) r_free_found <= 1'b1;
                if (r_in_pool && (r_p_idx == r_off))
                    r_req_ok <= post_free || (r_rd_data.owner == r_mac);
            end

            if (load_out) r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p_idx <= r_cnt[IW-1:0];
        if (s_accept) begin
            r_action  <= t_action'(i_s_axis_tuser);
            r_mac     <= i_s_axis_tdata[47:0];
            r_now     <= i_s_axis_tdata[79:48];
            r_want    <= i_s_axis_tdata[80] ? i_s_axis_tdata[112:81] : i_s_axis_tdata[144:113];
            r_has_sid <= i_s_axis_tdata[145];
            r_sid     <= i_s_axis_tdata[177:146];
        end
        if (r_state == S_PREP) begin
            r_n       <= pool_n;
            r_exp     <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
            r_off     <= off_full[IW-1:0];
            r_in_pool <= off_full < 32'(pool_n);
            r_sid_bad <= r_has_sid && (r_sid != r_server);
        end
        if (r_p_v && r_state == S_SWEEP) begin
            if (owned && !r_own_found) r_own_idx <= r_p_idx;
            if (post_free && !r_free_found) r_free_idx <= r_p_idx;
        end
        if (load_out) begin
            r_out_kind <= fin_kind;
            r_out_addr <= fin_addr;
            r_out_slot <= fin_slot;
        end
    end

endmodule

@@ design/dlpa_checker.sv @@
`include "dhcp_lease_pool_allocator_top_defines.svh"

module dlpa_checker import dlpa_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]             o_m_axis_tuser
);

    // hold the reply word while the receiver stalls
    `DLPA_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "reply word changed while stalled")

    // a taken request keeps the block busy for at least the next cycle
    `DLPA_ASSERT_NEXT(a_busy_after_take, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "ready straight after a request was taken")

    // a refusal carries neither address nor slot
    `DLPA_ASSERT_NOW(a_nak_clean, o_m_axis_tvalid && (o_m_axis_tuser == RK_NAK), o_m_axis_tdata == '0, "NAK with address or slot set")

    // no reply never gives an address away
    `DLPA_ASSERT_NOW(a_none_no_addr, o_m_axis_tvalid && (o_m_axis_tuser == RK_NONE), o_m_axis_tdata[31:0] == 32'd0, "address given without a reply")

endmodule

bind dhcp_lease_pool_allocator_top dlpa_checker u_dlpa_checker (.*);

@@ test/tb_dhcp_lease_pool_allocator_top.sv @@
`timescale 1ns / 1ps

module tb_dhcp_lease_pool_allocator_top;
    import dlpa_pkg::*;

    localparam int SLOTS = 256;

    localparam logic [47:0] MAC_A    = 48'h02_00_5E_00_00_A1;
    localparam logic [47:0] MAC_B    = 48'h02_00_5E_00_00_B2;
    localparam logic [47:0] MAC_C    = 48'h02_00_5E_00_00_C3;
    localparam logic [47:0] MAC_E    = 48'h02_00_5E_00_00_E5;
    localparam logic [47:0] MAC_ZERO = 48'h0;
    localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        t_action     action;
        logic [47:0] mac;
        logic [31:0] now;
        logic        has_req;
        logic [31:0] req_ip;
        logic [31:0] ci_ip;
        logic        has_sid;
        logic [31:0] sid;
    } lease_msg_t;

    typedef struct {
        t_reply      kind;
        logic [31:0] addr;
        logic [7:0]  slot;
    } lease_reply_t;

    // Mirror of the slot table and registers; predicts one reply per request word
    class lease_scoreboard;
        t_slot_st     status [SLOTS];
        logic [47:0]  owner  [SLOTS];
        logic [31:0]  expiry [SLOTS];
        logic [31:0]  base   = '0;
        logic [8:0]   size   = POOL_SIZE_RST;
        logic [31:0]  lease  = LEASE_RST;
        logic [15:0]  hold   = HOLD_RST;
        logic [31:0]  server = '0;
        lease_reply_t replies_due [$];
        int           errors = 0;
        int           words_in = 0;
        int           kind_seen [4];

        function new();
            foreach (status[i]) begin
                status[i] = ST_FREE;
                owner[i]  = '0;
                expiry[i] = '0;
            end
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_POOL_BASE: base   = value;
                REG_POOL_SIZE: size   = value[8:0];
                REG_LEASE:     lease  = value;
                REG_HOLD:      hold   = value[15:0];
                REG_SERVER:    server = value;
                default: ;
            endcase
        endfunction

        function int active();
            return (int'(size) > SLOTS) ? SLOTS : int'(size);
        endfunction

        function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function int owned_slot(logic [47:0] mac);
            for (int i = 0; i < active(); i++)
                if (status[i] != ST_FREE && owner[i] == mac) return i;
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < active(); i++)
                if (status[i] == ST_FREE) return i;
            return -1;
        endfunction

        function void note_request(lease_msg_t m);
            int           n;
            int           idx;
            logic [31:0]  want;
            logic [31:0]  off;
            lease_reply_t r;
            n = active();
            r.kind = RK_NONE;
            r.addr = '0;
            r.slot = '0;
            words_in++;
            // expire stale slots before the action
            for (int i = 0; i < n; i++) begin
                if (status[i] != ST_FREE && expiry[i] <= m.now) begin
                    status[i] = ST_FREE;
                    owner[i]  = '0;
                end
            end
            case (m.action)
                ACT_DISCOVER: begin
                    idx = owned_slot(m.mac);
                    if (idx < 0) idx = free_slot();
                    if (idx >= 0) begin
                        status[idx] = ST_OFFERED;
                        owner[idx]  = m.mac;
                        expiry[idx] = sat_sum(m.now, {16'd0, hold});
                        r.kind = RK_OFFER;
                        r.addr = base + 32'(idx);
                        r.slot = 8'(idx);
                    end
                end
                ACT_REQUEST: begin
                    // foreign server id: drop silently
                    if (!(m.has_sid && m.sid != server)) begin
                        want = m.has_req ? m.req_ip : m.ci_ip;
                        off  = want - base;
                        if (off < 32'(n) && (status[off] == ST_FREE || owner[off] == m.mac)) begin
                            status[off] = ST_BOUND;
                            owner[off]  = m.mac;
                            expiry[off] = sat_sum(m.now, lease);
                            r.kind = RK_ACK;
                            r.addr = want;
                            r.slot = off[7:0];
                        end else begin
                            r.kind = RK_NAK;
                        end
                    end
                end
                ACT_RELEASE: begin
                    idx = owned_slot(m.mac);
                    if (idx >= 0) begin
                        status[idx] = ST_FREE;
                        owner[idx]  = '0;
                        r.slot = 8'(idx);
                    end
                end
                default: ;
            endcase
            replies_due.push_back(r);
        endfunction

        function void check_reply(lease_reply_t got);
            lease_reply_t want;
            if (replies_due.size() == 0) begin
                $error("reply word with nothing expected: kind %0d addr %h slot %0d",
                       got.kind, got.addr, got.slot);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            kind_seen[want.kind]++;
            if (got.kind !== want.kind) begin
                $error("reply_kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.addr !== want.addr) begin
                $error("your_address: expected %h, got %h", want.addr, got.addr);
                errors++;
            end
            if (got.slot !== want.slot) begin
                $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // [47:0] client_mac, [79:48] now_seconds, [80] has_requested_option,
    // [112:81] requested_option_ip, [144:113] client_ip, [145] has_server_id,
    // [177:146] server_id_value, [183:178] zero
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    // [1:0] action
    logic [1:0]             i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // [31:0] your_address, [39:32] slot_index
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // [1:0] reply_kind
    logic [1:0]             o_m_axis_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    lease_scoreboard sb;
    logic [47:0]     macs [6];
    logic [31:0]     now_cursor;
    bit              calm_tx = 1'b0;
    bit              calm_rx = 1'b0;
    int              settings_run = 0;

    dhcp_lease_pool_allocator_top #(.POOL_SLOTS(SLOTS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Setup cycle, access cycle, register taken at the edge with pready high
    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Called at a clock edge; returns at the edge the word is accepted, valid still high
    task automatic send_word(lease_msg_t m);
        int gap;
        if ($urandom_range(0, 31) == 0) calm_tx = !calm_tx;
        gap = calm_tx ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, m.sid, m.has_sid, m.ci_ip, m.req_ip, m.has_req,
                            m.now, m.mac};
        i_s_axis_tuser  <= m.action;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sb.note_request(m);
    endtask

    // Sample at the falling edge so the reply sink's pop at the rising edge cannot race
    task automatic wait_drained();
        while (sb.replies_due.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic lease_msg_t mk_msg(t_action action, logic [47:0] mac, logic [31:0] now,
                                          logic has_req, logic [31:0] req_ip,
                                          logic [31:0] ci_ip, logic has_sid,
                                          logic [31:0] sid);
        lease_msg_t m;
        m.action  = action;
        m.mac     = mac;
        m.now     = now;
        m.has_req = has_req;
        m.req_ip  = req_ip;
        m.ci_ip   = ci_ip;
        m.has_sid = has_sid;
        m.sid     = sid;
        return m;
    endfunction

    // Mostly client traffic on a handful of MACs with a creeping clock; some noise
    function automatic lease_msg_t random_msg();
        lease_msg_t  m;
        int          roll;
        int          held;
        logic [31:0] target;
        m.mac = ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom})
                                              : macs[$urandom_range(0, 5)];
        roll = $urandom_range(0, 63);
        if (roll == 0) now_cursor = $urandom;
        else if (roll < 4) now_cursor += $urandom_range(50, 5000);
        else now_cursor += $urandom_range(0, 3);
        m.now     = now_cursor;
        m.req_ip  = $urandom;
        m.ci_ip   = $urandom;
        m.sid     = $urandom;
        m.has_req = 1'b0;
        m.has_sid = 1'b0;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            m.action = ACT_DISCOVER;
        end else if (roll < 65) begin
            m.action = ACT_REQUEST;
            held = sb.owned_slot(m.mac);
            // ask for the slot on offer, a pool neighbour, or somewhere else
            if (held >= 0 && $urandom_range(0, 9) < 6) target = sb.base + 32'(held);
            else if ($urandom_range(0, 9) < 7)
                target = sb.base + 32'($urandom_range(0, sb.active()));
            else target = $urandom;
            m.has_req = ($urandom_range(0, 9) < 7);
            if (m.has_req) m.req_ip = target;
            else m.ci_ip = target;
            roll = $urandom_range(0, 9);
            if (roll >= 5) m.has_sid = 1'b1;
            if (roll >= 5 && roll < 9) m.sid = sb.server;
        end else if (roll < 85) begin
            m.action = ACT_RELEASE;
        end else if (roll < 92) begin
            m.action = ACT_SWEEP;
        end else begin
            m.action  = t_action'($urandom_range(0, 3));
            m.has_req = 1'($urandom_range(0, 1));
            m.has_sid = 1'($urandom_range(0, 1));
            m.now     = $urandom;
        end
        return m;
    endfunction

    task automatic run_setting(logic [31:0] base, logic [8:0] size, logic [31:0] lease,
                               logic [15:0] hold, logic [31:0] server, int count);
        wait_drained();
        apb_write(REG_POOL_BASE, base);
        apb_write(REG_POOL_SIZE, 32'(size));
        apb_write(REG_LEASE, lease);
        apb_write(REG_HOLD, 32'(hold));
        apb_write(REG_SERVER, server);
        foreach (macs[k]) macs[k] = 48'({$urandom, $urandom});
        now_cursor = $urandom_range(0, 100000);
        for (int i = 0; i < count; i++) send_word(random_msg());
        i_s_axis_tvalid <= 1'b0;
        settings_run++;
    endtask

    // Reply sink: random back-pressure, check every accepted word
    initial begin : reply_sink
        int           stall;
        lease_reply_t got;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) calm_rx = !calm_rx;
            stall = calm_rx ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            got.kind = t_reply'(o_m_axis_tuser);
            got.addr = o_m_axis_tdata[31:0];
            got.slot = o_m_axis_tdata[39:32];
            sb.check_reply(got);
        end
    end

    initial begin : stimulus
        logic [31:0] pb;
        sb = new();
        pb = 32'hC0A8_0A00;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: four-slot pool, short hold, matching server id
        apb_write(REG_POOL_BASE, pb);
        apb_write(REG_POOL_SIZE, 32'd4);
        apb_write(REG_LEASE, 32'd100);
        apb_write(REG_HOLD, 32'd10);
        apb_write(REG_SERVER, pb + 32'd1);
        send_word(mk_msg(ACT_DISCOVER, MAC_A, 32'd1000, 1'b0, '0, '0, 1'b0, '0));
        // same client again: reuse its slot
        send_word(mk_msg(ACT_DISCOVER, MAC_A, 32'd1001, 1'b0, '0, '0, 1'b0, '0));
        send_word(mk_msg(ACT_DISCOVER, MAC_B, 32'd1002, 1'b0, '0, '0, 1'b0, '0));
        send_word(mk_msg(ACT_DISCOVER, MAC_ZERO, 32'd1003, 1'b0, '0, '0, 1'b0, '0));
        send_word(mk_msg(ACT_DISCOVER, MAC_ONES, 32'd1004, 1'b0, '0, '0, 1'b0, '0));
        // pool exhausted
        send_word(mk_msg(ACT_DISCOVER, MAC_E, 32'd1005, 1'b0, '0, '0, 1'b0, '0));
        send_word(mk_msg(ACT_REQUEST, MAC_A, 32'd1006, 1'b1, pb, '0, 1'b1, pb + 32'd1));
        // foreign server id
        send_word(mk_msg(ACT_REQUEST, MAC_B, 32'd1006, 1'b1, pb + 32'd1, '0, 1'b1,
                         32'hDEAD_BEEF));
        // address from ciaddr
        send_word(mk_msg(ACT_REQUEST, MAC_B, 32'd1007, 1'b0, 32'hFFFF_FFFF, pb + 32'd1,
                         1'b0, '0));
        // slot held by another client, then an address outside the pool
        send_word(mk_msg(ACT_REQUEST, MAC_E, 32'd1007, 1'b1, pb + 32'd2, '0, 1'b0, '0));
        send_word(mk_msg(ACT_REQUEST, MAC_E, 32'd1007, 1'b1, 32'hFFFF_FFFF, '0, 1'b0, '0));
        send_word(mk_msg(ACT_RELEASE, MAC_A, 32'd1008, 1'b0, '0, '0, 1'b0, '0));
        // release by a client that holds nothing
        send_word(mk_msg(ACT_RELEASE, MAC_E, 32'd1008, 1'b0, '0, '0, 1'b0, '0));
        // sweep only, once two offers have run out, one of them right on its expiry
        send_word(mk_msg(ACT_SWEEP, MAC_C, 32'd1014, 1'b1, pb, pb, 1'b1, pb));
        send_word(mk_msg(ACT_DISCOVER, MAC_E, 32'd1015, 1'b0, '0, '0, 1'b0, '0));
        send_word(mk_msg(ACT_REQUEST, MAC_E, 32'd1016, 1'b1, pb + 32'd3, 32'h1234_5678,
                         1'b0, '0));
        // hold and lease saturate near the top of time
        send_word(mk_msg(ACT_DISCOVER, MAC_C, 32'hFFFF_FFF8, 1'b0, '0, '0, 1'b0, '0));
        send_word(mk_msg(ACT_REQUEST, MAC_C, 32'hFFFF_FFF0, 1'b0, '0, pb, 1'b1, pb + 32'd1));
        send_word(mk_msg(ACT_SWEEP, MAC_ZERO, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0, '0));
        send_word(mk_msg(ACT_RELEASE, MAC_C, 32'd5, 1'b0, '0, '0, 1'b0, '0));
        // one past the last slot
        send_word(mk_msg(ACT_REQUEST, MAC_A, 32'd6, 1'b1, pb + 32'd4, '0, 1'b1, pb + 32'd1));
        i_s_axis_tvalid <= 1'b0;
        settings_run++;

        run_setting(32'h0A00_0000, 9'd8, 32'd40, 16'd5, 32'h0A00_0001, 120);
        // base wraps past the top of the address space; all times at their maximum
        run_setting(32'hFFFF_FFFC, 9'd6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 80);
        run_setting($urandom, 9'd1, 32'd0, 16'd0, 32'd0, 60);
        // empty pool
        run_setting($urandom, 9'd0, 32'd20, 16'd3, $urandom, 30);
        // oversize pool clamps to the full table; keep these short, they are slow
        run_setting(32'h0A00_0000, 9'h1FF, 32'd500, 16'd30, 32'h0A00_0001, 12);
        run_setting(32'hAC10_0000, 9'd256, 32'd3600, 16'd30, 32'd0, 12);
        run_setting(32'd0, 9'd3, 32'd7, 16'd2, 32'h0A00_0001, 140);
        run_setting(32'h0A00_0000, 9'd16, 32'd60, 16'd4, 32'h0A00_0001, 110);

        // drain, then keep watching for any stray word
        wait_drained();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (sb.replies_due.size() != 0) begin
            $error("%0d expected reply words never arrived", sb.replies_due.size());
            sb.errors++;
        end
        $display("covered %0d request words under %0d pool settings",
                 sb.words_in, settings_run);
        $display("replies seen: %0d offers, %0d acks, %0d naks, %0d silent",
                 sb.kind_seen[RK_OFFER], sb.kind_seen[RK_ACK], sb.kind_seen[RK_NAK],
                 sb.kind_seen[RK_NONE]);
        if (sb.errors == 0) begin
            $display("tb_dhcp_lease_pool_allocator_top: PASS");
        end else begin
            $display("tb_dhcp_lease_pool_allocator_top: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("tb_dhcp_lease_pool_allocator_top: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/dlpa_pkg.sv
design/dhcp_lease_pool_allocator_top.sv
design/dlpa_checker.sv
test/tb_dhcp_lease_pool_allocator_top.sv
